// ===== hdl/isaac_pkg.sv =====
// ----------------------------------------------------------------------------
// ISAAC package
// Shared constants, item codes and the scramble round of the set-up mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package isaac_pkg;

  localparam int unsigned LOG_SIZE_DEF = 8;
  localparam logic [31:0] GOLDEN = 32'h9e3779b9;

  // Item codes carried in the input tuser field.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_INIT = 2'd1;
  localparam logic [1:0] OP_EMIT = 2'd2;

  typedef logic [7:0][31:0] word8_t;

  // One line of the eight-word scramble; line k updates words k, k+1 and k+3.
  function automatic word8_t scramble_line(word8_t w, logic [2:0] k);
    word8_t r;
    logic [2:0] k1;
    logic [2:0] k2;
    logic [2:0] k3;
    logic [31:0] t;
    r = w;
    k1 = k + 3'd1;
    k2 = k + 3'd2;
    k3 = k + 3'd3;
    case (k)
      3'd0: t = w[k1] << 11;
      3'd1: t = w[k1] >> 2;
      3'd2: t = w[k1] << 8;
      3'd3: t = w[k1] >> 16;
      3'd4: t = w[k1] << 10;
      3'd5: t = w[k1] >> 4;
      3'd6: t = w[k1] << 8;
      default: t = w[k1] >> 9;
    endcase
    r[k] = w[k] ^ t;
    r[k3] = w[k3] + r[k];
    r[k1] = w[k1] + w[k2];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/isaac_ram.sv =====
// ----------------------------------------------------------------------------
// ISAAC generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module isaac_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/isaac_keystream_generator.sv =====
// ----------------------------------------------------------------------------
// ISAAC keystream generator
// 32-bit ISAAC with mixing memory and result buffer in two synchronous RAMs.
// ----------------------------------------------------------------------------
// A load request is written into the result buffer in the cycle it is
// accepted; an emit request with words left in the buffer goes through a
// read state and a delivery state that waits while the output is full.
// An emit request that finds the buffer used up first regenerates it,
// stepping each word through S_G1 to S_G5 and the single mixing-memory read port.
// An initialize request runs the golden-ratio scramble and two set-up
// passes in groups of eight words, then one regeneration. After reset a
// clearing pass zeroes both memories while no request is accepted.
`default_nettype none

module isaac_keystream_generator #(
  parameter int unsigned LOG_SIZE = isaac_pkg::LOG_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // seed_word [31:0]
  input  wire logic [1:0]  s_axis_tuser,   // opcode [1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // random_word [31:0]
);

  import isaac_pkg::*;

  localparam int unsigned L = LOG_SIZE;
  localparam logic [L:0] SIZE = (L+1)'(1) << L;
  localparam logic [L-1:0] LAST = {L{1'b1}};
  localparam logic [L-1:0] HALF = L'(1) << (L - 1);
  localparam logic [L-1:0] LAST_CHUNK = LAST - L'(7);

  // Sequencer states.
  typedef enum logic [14:0] {
    S_CLR  = 15'b000000000000001,
    S_IDLE = 15'b000000000000010,
    S_GOLD = 15'b000000000000100,
    S_IRD  = 15'b000000000001000,
    S_IACC = 15'b000000000010000,
    S_ISCR = 15'b000000000100000,
    S_IWR  = 15'b000000001000000,
    S_GST  = 15'b000000010000000,
    S_G1   = 15'b000000100000000,
    S_G2   = 15'b000001000000000,
    S_G3   = 15'b000010000000000,
    S_G4   = 15'b000100000000000,
    S_G5   = 15'b001000000000000,
    S_ERD  = 15'b010000000000000,
    S_EOUT = 15'b100000000000000
  } state_t;

  state_t      state;
  logic [L-1:0] addr;
  logic [2:0]  sub;
  logic [1:0]  scnt;
  logic        pass;
  logic        gen_emit;
  logic [31:0] acc;
  logic [31:0] prev;
  logic [31:0] cnt;
  logic [L:0]  pos;
  logic [L-1:0] lidx;
  word8_t      w;
  logic [31:0] x;
  logic [31:0] y;

  logic          mm_we;
  logic [L-1:0]  mm_waddr;
  logic [31:0]   mm_wdata;
  logic [L-1:0]  mm_raddr;
  logic [31:0]   mm_rdata;
  logic          rb_we;
  logic [L-1:0]  rb_waddr;
  logic [31:0]   rb_wdata;
  logic [L-1:0]  rb_raddr;
  logic [31:0]   rb_rdata;

  logic          accept;
  logic [L-1:0]  idx;
  logic [31:0]   mv;
  logic [31:0]   y_sum;
  logic [31:0]   b_sum;
  logic [31:0]   cnt_next;

  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  // Word address inside the current group of eight during set-up.
  assign idx = addr + L'(sub);
  assign y_sum = mm_rdata + acc + prev;
  assign b_sum = mm_rdata + x;
  assign cnt_next = cnt + 32'd1;

  always_comb begin
    case (addr[1:0])
      2'd0: mv = acc << 13;
      2'd1: mv = acc >> 6;
      2'd2: mv = acc << 2;
      default: mv = acc >> 16;
    endcase
  end

  // Memory port control.
  always_comb begin
    mm_we = 1'b0;
    mm_waddr = addr;
    mm_wdata = 32'd0;
    mm_raddr = addr;
    rb_we = 1'b0;
    rb_waddr = addr;
    rb_wdata = 32'd0;
    rb_raddr = pos[L-1:0];
    unique case (state)
      S_CLR: begin
        mm_we = 1'b1;
        rb_we = 1'b1;
      end
      S_IDLE: begin
        rb_we = accept && (s_axis_tuser == OP_LOAD);
        rb_waddr = lidx;
        rb_wdata = s_axis_tdata;
      end
      S_IRD: begin
        mm_raddr = idx;
        rb_raddr = idx;
      end
      S_IWR: begin
        mm_we = 1'b1;
        mm_waddr = idx;
        mm_wdata = w[sub];
      end
      S_GST: mm_raddr = '0;
      S_G1: mm_raddr = addr ^ HALF;
      S_G2: mm_raddr = x[L+1:2];
      S_G3: begin
        mm_we = 1'b1;
        mm_wdata = y_sum;
        mm_raddr = x[L+1:2];
      end
      S_G4: mm_raddr = y[2*L+1:L+2];
      S_G5: begin
        rb_we = 1'b1;
        rb_wdata = b_sum;
        mm_raddr = addr + L'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      addr <= '0;
      sub <= '0;
      scnt <= '0;
      pass <= 1'b0;
      gen_emit <= 1'b0;
      acc <= '0;
      prev <= '0;
      cnt <= '0;
      pos <= '0;
      lidx <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_EOUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          addr <= addr + L'(1);
          if (addr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (s_axis_tuser)
              OP_LOAD: lidx <= lidx + L'(1);
              OP_INIT: begin
                // The set-up words all start at the golden ratio.
                w <= {8{GOLDEN}};
                sub <= '0;
                scnt <= '0;
                acc <= '0;
                prev <= '0;
                cnt <= '0;
                state <= S_GOLD;
              end
              OP_EMIT: begin
                if (pos == '0) begin
                  gen_emit <= 1'b1;
                  state <= S_GST;
                end else begin
                  pos <= pos - (L+1)'(1);
                  state <= S_ERD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_GOLD: begin
          w <= scramble_line(w, sub);
          sub <= sub + 3'd1;
          if (sub == 3'd7) begin
            scnt <= scnt + 2'd1;
            if (scnt == 2'd3) begin
              addr <= '0;
              pass <= 1'b0;
              state <= S_IRD;
            end
          end
        end
        S_IRD: state <= S_IACC;
        S_IACC: begin
          w[sub] <= w[sub] + (pass ? mm_rdata : rb_rdata);
          sub <= sub + 3'd1;
          state <= (sub == 3'd7) ? S_ISCR : S_IRD;
        end
        S_ISCR: begin
          w <= scramble_line(w, sub);
          sub <= sub + 3'd1;
          if (sub == 3'd7) begin
            state <= S_IWR;
          end
        end
        S_IWR: begin
          sub <= sub + 3'd1;
          if (sub == 3'd7) begin
            if (addr == LAST_CHUNK) begin
              addr <= '0;
              if (pass) begin
                gen_emit <= 1'b0;
                state <= S_GST;
              end else begin
                pass <= 1'b1;
                state <= S_IRD;
              end
            end else begin
              addr <= addr + L'(8);
              state <= S_IRD;
            end
          end
        end
        S_GST: begin
          cnt <= cnt_next;
          prev <= prev + cnt_next;
          addr <= '0;
          state <= S_G1;
        end
        S_G1: begin
          x <= mm_rdata;
          state <= S_G2;
        end
        S_G2: begin
          acc <= (acc ^ mv) + mm_rdata;
          state <= S_G3;
        end
        S_G3: begin
          y <= y_sum;
          state <= S_G4;
        end
        S_G4: state <= S_G5;
        S_G5: begin
          prev <= b_sum;
          addr <= addr + L'(1);
          if (addr == LAST) begin
            if (gen_emit) begin
              pos <= SIZE - (L+1)'(1);
              state <= S_ERD;
            end else begin
              pos <= SIZE;
              lidx <= '0;
              state <= S_IDLE;
            end
          end else begin
            state <= S_G1;
          end
        end
        // The buffer read at the new position is issued here, so that the
        // registered word is ready in the delivery state.
        S_ERD: state <= S_EOUT;
        S_EOUT: begin
          // The buffer read at the current position repeats every cycle, so
          // the word is ready here and waits for the output register to free.
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= rb_rdata;
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  isaac_ram #(.WIDTH(32), .ADDR_W(L)) u_mix_ram (
    .clk   (clk),
    .we    (mm_we),
    .waddr (mm_waddr),
    .wdata (mm_wdata),
    .raddr (mm_raddr),
    .rdata (mm_rdata)
  );

  isaac_ram #(.WIDTH(32), .ADDR_W(L)) u_res_ram (
    .clk   (clk),
    .we    (rb_we),
    .waddr (rb_waddr),
    .wdata (rb_wdata),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  // A new result only ever comes out of the delivery state.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_EOUT))
    else $error("result appeared outside delivery");

  // A stalled delivery keeps waiting instead of dropping the word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EOUT && m_axis_tvalid && !m_axis_tready) |=> (state == S_EOUT))
    else $error("delivery left while output busy");

  // The last step of an emit-driven refill hands out the top buffer word.
  a_refill_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_G5 && addr == LAST && gen_emit)
      |=> (state == S_ERD && pos == SIZE - (L+1)'(1)))
    else $error("refill did not set top position");

endmodule

`default_nettype wire
